FILE: src/fcd_pkg.sv
// Shared types, codes and lookup functions for the FASC-N character decoder.
package fcd_pkg;

   localparam int unsigned RecordBytesDefault = 25;

   localparam int unsigned ByteW  = 8;
   localparam int unsigned CodeW  = 4;
   localparam int unsigned SymW   = 5;
   localparam int unsigned PosW   = 6;
   localparam int unsigned TagW   = 4;
   localparam int unsigned PendW  = 4;
   localparam int unsigned PCntW  = 3;

   localparam int unsigned RspDataW = 16;   // code + symbol + position, padded to bytes
   localparam int unsigned RspUserW = 5;    // field tag + record done

   // character codes
   localparam logic [CodeW-1:0] CODE_SS  = 4'd10;
   localparam logic [CodeW-1:0] CODE_FS  = 4'd11;
   localparam logic [CodeW-1:0] CODE_ES  = 4'd12;
   localparam logic [CodeW-1:0] CODE_BAD = 4'd13;

   // field tags
   localparam logic [TagW-1:0] TAG_NONE   = 4'd0;
   localparam logic [TagW-1:0] TAG_AGENCY = 4'd1;
   localparam logic [TagW-1:0] TAG_SYSTEM = 4'd2;
   localparam logic [TagW-1:0] TAG_CRED   = 4'd3;
   localparam logic [TagW-1:0] TAG_SERIES = 4'd4;
   localparam logic [TagW-1:0] TAG_ISSUE  = 4'd5;
   localparam logic [TagW-1:0] TAG_PERSON = 4'd6;
   localparam logic [TagW-1:0] TAG_ORGCAT = 4'd7;
   localparam logic [TagW-1:0] TAG_ORGID  = 4'd8;
   localparam logic [TagW-1:0] TAG_ASSOC  = 4'd9;

   typedef struct packed {
      logic [PendW-1:0] pending_bits;
      logic [PCntW-1:0] pending_count;
      logic [PosW-1:0]  char_counter;
   } dec_state_type;

   typedef struct packed {
      logic [CodeW-1:0] char_code;
      logic [SymW-1:0]  raw_symbol;
      logic [PosW-1:0]  char_position;
      logic [TagW-1:0]  field_tag;
      logic             record_done;
      logic             last_of_run;
   } char_result_type;

   function automatic logic [CodeW-1:0] map_symbol(input logic [SymW-1:0] sym);
      logic [CodeW-1:0] code;
      case (sym)
         5'h01:   code = 4'd0;
         5'h10:   code = 4'd1;
         5'h08:   code = 4'd2;
         5'h19:   code = 4'd3;
         5'h04:   code = 4'd4;
         5'h15:   code = 4'd5;
         5'h0D:   code = 4'd6;
         5'h1C:   code = 4'd7;
         5'h02:   code = 4'd8;
         5'h13:   code = 4'd9;
         5'h1A:   code = CODE_SS;
         5'h16:   code = CODE_FS;
         5'h1F:   code = CODE_ES;
         default: code = CODE_BAD;
      endcase
      return code;
   endfunction

   function automatic logic [TagW-1:0] field_of(input logic [PosW-1:0] pos);
      logic [TagW-1:0] tag;
      if (pos >= 6'd1 && pos <= 6'd4)        tag = TAG_AGENCY;
      else if (pos >= 6'd6 && pos <= 6'd9)   tag = TAG_SYSTEM;
      else if (pos >= 6'd11 && pos <= 6'd16) tag = TAG_CRED;
      else if (pos == 6'd18)                 tag = TAG_SERIES;
      else if (pos == 6'd20)                 tag = TAG_ISSUE;
      else if (pos >= 6'd22 && pos <= 6'd31) tag = TAG_PERSON;
      else if (pos == 6'd32)                 tag = TAG_ORGCAT;
      else if (pos >= 6'd33 && pos <= 6'd36) tag = TAG_ORGID;
      else if (pos == 6'd37)                 tag = TAG_ASSOC;
      else                                   tag = TAG_NONE;
      return tag;
   endfunction

endpackage

FILE: src/fcd_slicer.sv
// Cuts one byte plus leftover bits into up to two decoded 5-bit characters.
module fcd_slicer #(
   parameter int unsigned RECORD_BYTES = fcd_pkg::RecordBytesDefault
) (
   input  fcd_pkg::dec_state_type   state_cur,
   input  logic [7:0]               data_byte,
   input  logic                     record_start,
   output fcd_pkg::char_result_type res0,
   output fcd_pkg::char_result_type res1,
   output logic                     two_chars,
   output fcd_pkg::dec_state_type   state_nxt
);
   import fcd_pkg::*;

   localparam int unsigned RecordChars = (RECORD_BYTES * 8) / 5;
   localparam logic [PosW:0] LastPos   = (PosW+1)'(RecordChars - 1);

   logic [PendW-1:0] pb;
   logic [PCntW-1:0] pc;
   logic [PosW-1:0]  pos0;
   logic [PosW-1:0]  pos1;
   logic [11:0]      acc;
   logic [SymW-1:0]  sym0;
   logic [SymW-1:0]  sym1;
   logic             done0;
   logic             done1;
   logic             ended;
   logic [3:0]       left_cnt;
   logic [PendW-1:0] keep_mask;

   always_comb begin
      pb   = record_start ? '0 : state_cur.pending_bits;
      pc   = record_start ? '0 : state_cur.pending_count;
      pos0 = record_start ? '0 : state_cur.char_counter;
      pos1 = pos0 + 6'd1;
      acc  = {pb, data_byte};

      // first symbol sits pc+3 bits up, second (when pc >= 2) pc-2 bits up
      sym0  = 5'(acc >> ({1'b0, pc} + 4'd3));
      sym1  = 5'(acc >> (pc - 3'd2));
      done0 = {1'b0, pos0} >= LastPos;
      done1 = {1'b0, pos1} >= LastPos;

      two_chars = (pc >= 3'd2) && !done0;
      ended     = done0 || (two_chars && done1);

      res0.char_code     = map_symbol(sym0);
      res0.raw_symbol    = sym0;
      res0.char_position = pos0;
      res0.field_tag     = field_of(pos0);
      res0.record_done   = done0;
      res0.last_of_run   = !two_chars;

      res1.char_code     = map_symbol(sym1);
      res1.raw_symbol    = sym1;
      res1.char_position = pos1;
      res1.field_tag     = field_of(pos1);
      res1.record_done   = done1;
      res1.last_of_run   = 1'b1;

      left_cnt  = two_chars ? {1'b0, pc - 3'd2} : ({1'b0, pc} + 4'd3);
      keep_mask = PendW'((5'd1 << left_cnt) - 5'd1);

      if (ended) begin
         state_nxt = '0;
      end else begin
         state_nxt.pending_count = left_cnt[PCntW-1:0];
         state_nxt.pending_bits  = acc[PendW-1:0] & keep_mask;
         state_nxt.char_counter  = two_chars ? (pos1 + 6'd1) : pos1;
      end
   end

endmodule

FILE: src/fascn_character_decoder_top.sv
// Top level of the FASC-N character decoder: byte intake, result buffer, output register.
//
//  channel | dir | handshake             | contents
//  --------+-----+-----------------------+---------------------------------------------
//  req     | in  | req_tvalid/req_tready | tdata: data byte; tuser: record start
//  rsp     | out | rsp_tvalid/rsp_tready | tdata: code, symbol, position; tuser: tag,
//          |     |                       | record done; tlast: last char of the byte
//
// Every byte yields one or two characters. A byte is decoded in the cycle of its
// transfer and its characters land in a two-entry buffer that drains one per cycle,
// while rsp is not stalled, into the rsp register; the single rsp port thus sets how
// fast bytes are taken. The next byte is taken in the cycle the buffer's last entry
// moves out. Reset (synchronous) clears the leftover bits, the character position and
// all valids. A stalled rsp holds its register and buffer.
module fascn_character_decoder_top #(
   parameter int unsigned RECORD_BYTES = fcd_pkg::RecordBytesDefault
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [7:0]                    req_tdata,   // [7:0] data_byte
   input  logic                          req_tuser,   // [0] record_start
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [fcd_pkg::RspDataW-1:0]  rsp_tdata,   // [3:0] char_code, [8:4] raw_symbol,
                                                      // [14:9] char_position, [15] zero
   output logic [fcd_pkg::RspUserW-1:0]  rsp_tuser,   // [3:0] field_tag, [4] record_done
   output logic                          rsp_tlast    // last_of_run
);
   import fcd_pkg::*;

   dec_state_type   state_ff, state_in, state_nxt;
   char_result_type res0, res1;
   logic            two_chars;

   // two-entry buffer of decoded characters
   char_result_type pair_ff [2];
   char_result_type pair_in [2];
   logic [1:0]      rem_ff, rem_in;
   logic            head_ff, head_in;

   // output register
   char_result_type out_ff, out_in;
   logic            out_valid_ff, out_valid_in;

   logic req_xfer;
   logic move;

   fcd_slicer #(
      .RECORD_BYTES (RECORD_BYTES)
   ) u_slicer (
      .state_cur    (state_ff),
      .data_byte    (req_tdata),
      .record_start (req_tuser),
      .res0         (res0),
      .res1         (res1),
      .two_chars    (two_chars),
      .state_nxt    (state_nxt)
   );

   // a buffered character moves out when the rsp register is empty or being taken
   assign move       = (rem_ff != 2'd0) && (!out_valid_ff || rsp_tready);
   assign req_tready = (rem_ff == 2'd0) || ((rem_ff == 2'd1) && move);
   assign req_xfer   = req_tvalid && req_tready;

   always_comb begin
      state_in     = state_ff;
      pair_in      = pair_ff;
      rem_in       = rem_ff;
      head_in      = head_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff;

      if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
      if (move) begin
         out_in       = pair_ff[head_ff];
         out_valid_in = 1'b1;
         head_in      = head_ff + 1'b1;
         rem_in       = rem_ff - 2'd1;
      end
      if (req_xfer) begin
         state_in   = state_nxt;
         pair_in[0] = res0;
         pair_in[1] = res1;
         rem_in     = two_chars ? 2'd2 : 2'd1;
         head_in    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= '0;
         rem_ff       <= '0;
         head_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rem_ff       <= rem_in;
         head_ff      <= head_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      pair_ff <= pair_in;
      out_ff  <= out_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {1'b0, out_ff.char_position, out_ff.raw_symbol, out_ff.char_code};
   assign rsp_tuser  = {out_ff.record_done, out_ff.field_tag};
   assign rsp_tlast  = out_ff.last_of_run;

endmodule
